// ----- rtl/core/mbph_pkg.sv -----
// ----------------------------------------------------------------------------
// mbph_pkg: shared types, constants and release table
// Fixed-point formats, controller state and command types, and the release
// coefficient table (alpha, Q16) built once at elaboration.
// ----------------------------------------------------------------------------
`default_nettype none

package mbph_pkg;

  // Ballistics build constants
  localparam int RELEASE_TAU_MS = 300;
  localparam int ALPHA_DEPTH    = 256;
  localparam int ALPHA_IDX_W    = $clog2(ALPHA_DEPTH);

  // dBFS offset: 60 dB in 1/1024 dB
  localparam logic signed [17:0] DBFS_OFFSET = 18'sd61440;

  // First item uses this many ms for the release
  localparam logic [16:0] FIRST_DT_MS = 17'd8;

  // Reset values of the configuration registers
  localparam logic        RST_INPUT_MODE     = 1'b0;
  localparam logic [15:0] RST_MAX_LEVEL      = 16'd24576;
  localparam logic [16:0] RST_DBFS_SCALE     = 17'd26214;
  localparam logic [15:0] RST_PEAK_HOLD_MS   = 16'd800;
  localparam logic [15:0] RST_PEAK_FALL_RATE = 16'd1311;

  // Register indexes
  localparam logic [2:0] REG_INPUT_MODE     = 3'd0;
  localparam logic [2:0] REG_MAX_LEVEL      = 3'd1;
  localparam logic [2:0] REG_DBFS_SCALE     = 3'd2;
  localparam logic [2:0] REG_PEAK_HOLD_MS   = 3'd3;
  localparam logic [2:0] REG_PEAK_FALL_RATE = 3'd4;

  typedef struct packed {
    logic        input_mode;
    logic [15:0] max_level;
    logic [16:0] dbfs_scale;
    logic [15:0] peak_hold_ms;
    logic [15:0] peak_fall_rate;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_CLAMP,
    ST_REL,
    ST_METER,
    ST_UPD
  } ctl_state_t;

  typedef enum logic [1:0] {
    MUL_MAP,
    MUL_REL,
    MUL_FALL
  } mul_sel_t;

  typedef struct packed {
    logic     capture;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     clamp_en;
    logic     meter_en;
    logic     commit;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  typedef logic [16:0] alpha_rom_t [ALPHA_DEPTH];

  // Shift-subtract quotient, used only while building the table
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // alpha(d) = 1 - exp(-d/tau) in Q16, from r = exp(-1/tau) in Q32
  function automatic alpha_rom_t build_alpha();
    alpha_rom_t        rom;
    logic [63:0]       term;
    logic signed [65:0] sum;
    logic [63:0]       r;
    logic [63:0]       p;
    logic [63:0]       a;
    logic              done;
    term = 64'h1_0000_0000;
    sum  = 66'sh1_0000_0000;
    done = 1'b0;
    for (int k = 1; k < 64; k++) begin
      if (!done) begin
        term = div_u64(term, 64'(RELEASE_TAU_MS) * 64'(k));
        if (term == 64'd0) begin
          done = 1'b1;
        end else if (k % 2 == 1) begin
          sum = sum - $signed({2'b00, term});
        end else begin
          sum = sum + $signed({2'b00, term});
        end
      end
    end
    if (sum < 0) sum = '0;
    r = sum[63:0];
    if (r >= 64'h1_0000_0000) r = 64'hFFFF_FFFF;
    p = 64'h1_0000_0000;
    for (int d = 0; d < ALPHA_DEPTH; d++) begin
      p = (p * r + 64'h8000_0000) >> 32;
      a = (64'h1_0000_0000 - p + 64'd32768) >> 16;
      if (a > 64'd65536) a = 64'd65536;
      rom[d] = a[16:0];
    end
    return rom;
  endfunction

  localparam alpha_rom_t ALPHA_ROM = build_alpha();

endpackage

`default_nettype wire

// ----- rtl/core/mbph_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbph_ctrl: item sequencer
// Steps one request through map, clamp, release, meter and peak update,
// driving the datapath by commands.
// ----------------------------------------------------------------------------
`default_nettype none

module mbph_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  mbph_pkg::status_t status,
  output mbph_pkg::cmd_t   cmd
);
  import mbph_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MAP;
      ST_MAP:   state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_REL;
      ST_REL:   state_next = ST_METER;
      ST_METER: state_next = ST_UPD;
      ST_UPD:   if (!status.out_busy) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_MAP: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_MAP;
      end
      ST_CLAMP: begin
        cmd.clamp_en = 1'b1;
      end
      ST_REL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_REL;
      end
      ST_METER: begin
        cmd.meter_en = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_FALL;
      end
      ST_UPD: begin
        cmd.commit = !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/mbph_dp.sv -----
// ----------------------------------------------------------------------------
// mbph_dp: ballistics datapath
// Shared 17x17 multiplier, level clamp, release table, meter and peak state,
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbph_dp (
  input  wire                  clk,
  input  wire                  rst,
  input  mbph_pkg::cfg_t       cfg,
  input  mbph_pkg::cmd_t       cmd,
  output mbph_pkg::status_t    status,
  input  wire signed [16:0]    level,
  input  wire [15:0]           elapsed_ms,
  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [15:0]          meter_value,
  output logic [15:0]          peak_value,
  output logic                 changed
);
  import mbph_pkg::*;

  // Captured request and working registers
  logic signed [16:0] level_r;
  logic [15:0]        elapsed_r;
  logic [15:0]        meter_prev;
  logic [33:0]        prod;
  logic [15:0]        db;
  logic [16:0]        alpha;
  logic [15:0]        age_sum;

  // Ballistics state
  logic [15:0] meter_level;
  logic [15:0] peak_level;
  logic [15:0] peak_age_ms;
  logic        peak_active;
  logic        seen_first;

  // Multiplier operand select
  logic signed [17:0] shifted;
  logic [15:0]        diff;
  logic [15:0]        over_hold;
  logic [16:0]        mul_a;
  logic [16:0]        mul_b;

  assign shifted   = $signed({level_r[16], level_r}) + DBFS_OFFSET;
  assign diff      = meter_level - db;
  assign over_hold = age_sum - cfg.peak_hold_ms;

  always_comb begin
    case (cmd.mul_sel)
      MUL_MAP: begin
        mul_a = shifted[16:0];
        mul_b = cfg.dbfs_scale;
      end
      MUL_REL: begin
        mul_a = alpha;
        mul_b = {1'b0, diff};
      end
      MUL_FALL: begin
        mul_a = {1'b0, over_hold};
        mul_b = {1'b0, cfg.peak_fall_rate};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= 34'(mul_a) * 34'(mul_b);
  end

  // Level clamp into 0..max_level
  logic [17:0] lev_pos;
  logic [15:0] db_next;

  always_comb begin
    if (cfg.input_mode) begin
      lev_pos = shifted[17] ? 18'd0 : prod[33:16];
    end else begin
      lev_pos = level_r[16] ? 18'd0 : {1'b0, level_r};
    end
    db_next = (lev_pos > {2'b00, cfg.max_level}) ? cfg.max_level : lev_pos[15:0];
  end

  // Release step and table index
  logic [16:0]            dt;
  logic [ALPHA_IDX_W-1:0] alpha_idx;

  always_comb begin
    if (!seen_first) begin
      dt = FIRST_DT_MS;
    end else if (elapsed_r == 16'd0) begin
      dt = 17'd1;
    end else if ({1'b0, elapsed_r} > 17'(ALPHA_DEPTH)) begin
      dt = 17'(ALPHA_DEPTH);
    end else begin
      dt = {1'b0, elapsed_r};
    end
  end

  assign alpha_idx = ALPHA_IDX_W'(dt - 17'd1);

  // Saturating peak age
  logic [16:0] age_wide;
  assign age_wide = {1'b0, peak_age_ms} + {1'b0, elapsed_r};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      level_r    <= level;
      elapsed_r  <= elapsed_ms;
      meter_prev <= meter_level;
    end
    if (cmd.clamp_en) begin
      db      <= db_next;
      alpha   <= ALPHA_ROM[alpha_idx];
      age_sum <= age_wide[16] ? 16'hFFFF : age_wide[15:0];
    end
  end

  // Meter: instant rise, rounded exponential release
  logic [33:0] dec_round;
  logic [17:0] dec;
  logic [15:0] meter_fall;

  assign dec_round  = prod + 34'd32768;
  assign dec        = dec_round[33:16];
  assign meter_fall = (dec >= {2'b00, diff}) ? db : meter_level - dec[15:0];

  // Peak: hold, then linear fall floored at the meter
  logic [33:0] drop_round;
  logic [27:0] drop;
  logic [15:0] peak_fall;
  logic [15:0] peak_floor;
  logic        rise;
  logic        fall;

  assign drop_round = prod + 34'd32;
  assign drop       = drop_round[33:6];
  assign peak_fall  = (drop >= {12'd0, peak_level}) ? 16'd0 : peak_level - drop[15:0];
  assign peak_floor = (peak_fall < meter_level) ? meter_level : peak_fall;
  assign rise       = db > peak_level;
  assign fall       = peak_active && (age_sum > cfg.peak_hold_ms);

  logic [15:0] peak_next;
  logic [15:0] age_next;

  always_comb begin
    if (rise) begin
      peak_next = db;
      age_next  = 16'd0;
    end else if (fall) begin
      peak_next = peak_floor;
      age_next  = 16'd0;
    end else begin
      peak_next = peak_level;
      age_next  = age_sum;
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      meter_level <= '0;
      peak_level  <= '0;
      peak_age_ms <= '0;
      peak_active <= 1'b0;
      seen_first  <= 1'b0;
    end else begin
      if (cmd.meter_en) begin
        meter_level <= (db > meter_level) ? db : meter_fall;
      end
      if (cmd.commit) begin
        peak_level  <= peak_next;
        peak_age_ms <= age_next;
        seen_first  <= 1'b1;
        if (rise) peak_active <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      meter_value <= meter_level;
      peak_value  <= peak_next;
      changed     <= (meter_level != meter_prev) || (peak_next != peak_level);
    end
  end

  assign status.out_busy = out_valid && out_stall;

  // Checks
  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("result not presented after commit");

  // between requests the peak never sits below the meter
  a_peak_over_meter: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> (peak_level >= meter_level))
    else $error("peak below meter");

  a_idle_is_zero: assert property (@(posedge clk) disable iff (rst)
    !peak_active |-> (peak_level == 16'd0))
    else $error("peak held without an active peak");

  a_commit_seen: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> seen_first)
    else $error("first item flag not set");

endmodule

`default_nettype wire

// ----- rtl/core/meter_ballistics_peak_hold.sv -----
// ----------------------------------------------------------------------------
// meter_ballistics_peak_hold: level meter ballistics with peak hold
// Maps and clamps a level, applies instant-rise exponential release and a
// held, linearly falling peak; one result per request.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  in      | in_valid / in_stall   | level, elapsed_ms
//  out     | out_valid / out_stall | meter_value, peak_value, changed
//  cfg     | cfg_write             | cfg_index, cfg_data
//
//  Each request is captured, then run through five controller steps, three of
//  which use the single shared 17x17 multiplier (map, release, peak fall).
//  The next request is taken while the previous result waits in the output
//  register; the final step waits only if that register is still stalled.
//  Synchronous reset clears meter, peak, age and flags; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module meter_ballistics_peak_hold (
  input  wire               clk,
  input  wire               rst,
  input  wire               in_valid,
  output logic              in_stall,
  input  wire signed [16:0] level,
  input  wire [15:0]        elapsed_ms,
  output logic              out_valid,
  input  wire               out_stall,
  output logic [15:0]       meter_value,
  output logic [15:0]       peak_value,
  output logic              changed,
  input  wire               cfg_write,
  input  wire [2:0]         cfg_index,
  input  wire [16:0]        cfg_data
);
  import mbph_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.input_mode     <= RST_INPUT_MODE;
      cfg.max_level      <= RST_MAX_LEVEL;
      cfg.dbfs_scale     <= RST_DBFS_SCALE;
      cfg.peak_hold_ms   <= RST_PEAK_HOLD_MS;
      cfg.peak_fall_rate <= RST_PEAK_FALL_RATE;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_INPUT_MODE:     cfg.input_mode     <= cfg_data[0];
        REG_MAX_LEVEL:      cfg.max_level      <= cfg_data[15:0];
        REG_DBFS_SCALE:     cfg.dbfs_scale     <= cfg_data;
        REG_PEAK_HOLD_MS:   cfg.peak_hold_ms   <= cfg_data[15:0];
        REG_PEAK_FALL_RATE: cfg.peak_fall_rate <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  mbph_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mbph_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .level       (level),
    .elapsed_ms  (elapsed_ms),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .meter_value (meter_value),
    .peak_value  (peak_value),
    .changed     (changed)
  );

endmodule

`default_nettype wire
